/* rtl/tidp_pkg.sv */
// Shared types and constants for the TS information descriptor parser.
package tidp_pkg;

    // Parser phase while walking one descriptor payload.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_KEY    = 4'd1,
        PH_LEN    = 4'd2,
        PH_NAME   = 4'd3,
        PH_TTYPE  = 4'd4,
        PH_TCOUNT = 4'd5,
        PH_SVCHI  = 4'd6,
        PH_SVCLO  = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    // Record kinds carried in record_kind.
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_TRANS  = 3'd2;
    localparam logic [2:0] KIND_SVC    = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // One input item: a payload byte with its framing flags.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_flag;
        logic       end_flag;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  key_id;
        logic [5:0]  name_length;
        logic [1:0]  type_count;
        logic [15:0] field_value;
        logic [7:0]  service_count;
        logic [1:0]  transmission_index;
        logic        last;
        logic        descriptor_ok;
    } t_out_item;

    // Result of one parser step: whether a record is produced, and the record.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_res;

endpackage

/* rtl/tidp_parser.sv */
// Parser state and the single-byte step logic that emits at most one record.
module tidp_parser
    import tidp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_step_res o_res
);

    t_phase     r_phase,       n_phase;
    logic [7:0] r_key_store,   n_key_store;
    logic [5:0] r_name_left,   n_name_left;
    logic [1:0] r_trans_left,  n_trans_left;
    logic [7:0] r_svc_left,    n_svc_left;
    logic [7:0] r_svc_high,    n_svc_high;
    logic [1:0] r_trans_index, n_trans_index;

    t_phase     w_eff_phase;
    t_phase     w_walk_phase;
    logic [7:0] w_b;
    logic [5:0] w_name_dec;
    logic [1:0] w_trans_dec;
    logic [7:0] w_svc_dec;
    logic       w_active;

    // A start byte restarts the walk at the key id regardless of state.
    assign w_eff_phase = i_item.start_flag ? PH_KEY : r_phase;
    assign w_b         = i_item.byte_value;
    assign w_name_dec  = r_name_left - 6'd1;
    assign w_trans_dec = r_trans_left - 2'd1;
    assign w_svc_dec   = r_svc_left - 8'd1;
    assign w_active    = (w_eff_phase != PH_IDLE);

    // Next state: walk the structure, then an end byte sends the parser idle.
    always_comb begin
        w_walk_phase  = w_eff_phase;
        n_key_store   = r_key_store;
        n_name_left   = r_name_left;
        n_trans_left  = r_trans_left;
        n_svc_left    = r_svc_left;
        n_svc_high    = r_svc_high;
        n_trans_index = r_trans_index;
        unique case (w_eff_phase)
            PH_KEY: begin
                n_key_store  = w_b;
                w_walk_phase = PH_LEN;
            end
            PH_LEN: begin
                n_name_left   = w_b[7:2];
                n_trans_left  = w_b[1:0];
                n_trans_index = 2'd0;
                if (w_b[7:2] != 6'd0) begin
                    w_walk_phase = PH_NAME;
                end else if (w_b[1:0] != 2'd0) begin
                    w_walk_phase = PH_TTYPE;
                end else begin
                    w_walk_phase = PH_DONE;
                end
            end
            PH_NAME: begin
                n_name_left = w_name_dec;
                if (w_name_dec == 6'd0) begin
                    w_walk_phase = (r_trans_left != 2'd0) ? PH_TTYPE : PH_DONE;
                end
            end
            PH_TTYPE: begin
                n_svc_high   = w_b;
                w_walk_phase = PH_TCOUNT;
            end
            PH_TCOUNT: begin
                n_svc_left = w_b;
                if (w_b == 8'd0) begin
                    n_trans_left  = w_trans_dec;
                    n_trans_index = r_trans_index + 2'd1;
                    w_walk_phase  = (w_trans_dec != 2'd0) ? PH_TTYPE : PH_DONE;
                end else begin
                    w_walk_phase = PH_SVCHI;
                end
            end
            PH_SVCHI: begin
                n_svc_high   = w_b;
                w_walk_phase = PH_SVCLO;
            end
            PH_SVCLO: begin
                n_svc_left = w_svc_dec;
                if (w_svc_dec == 8'd0) begin
                    n_trans_left  = w_trans_dec;
                    n_trans_index = r_trans_index + 2'd1;
                    w_walk_phase  = (w_trans_dec != 2'd0) ? PH_TTYPE : PH_DONE;
                end else begin
                    w_walk_phase = PH_SVCHI;
                end
            end
            PH_DONE: begin
                w_walk_phase = PH_DONE;
            end
            default: begin
                w_walk_phase = r_phase;
            end
        endcase
        n_phase = (i_item.end_flag && w_active) ? PH_IDLE : w_walk_phase;
    end

    // Record output: one record per completed field, or an end-only record.
    always_comb begin
        o_res = '0;
        unique case (w_eff_phase)
            PH_LEN: begin
                o_res.valid            = 1'b1;
                o_res.item.record_kind = KIND_HEADER;
                o_res.item.key_id      = r_key_store;
                o_res.item.name_length = w_b[7:2];
                o_res.item.type_count  = w_b[1:0];
            end
            PH_NAME: begin
                o_res.valid            = 1'b1;
                o_res.item.record_kind = KIND_NAME;
                o_res.item.field_value = {8'd0, w_b};
            end
            PH_TCOUNT: begin
                o_res.valid                   = 1'b1;
                o_res.item.record_kind        = KIND_TRANS;
                o_res.item.field_value        = {8'd0, r_svc_high};
                o_res.item.service_count      = w_b;
                o_res.item.transmission_index = r_trans_index;
            end
            PH_SVCLO: begin
                o_res.valid                   = 1'b1;
                o_res.item.record_kind        = KIND_SVC;
                o_res.item.field_value        = {r_svc_high, w_b};
                o_res.item.transmission_index = r_trans_index;
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
        if (i_item.end_flag && w_active) begin
            if (!o_res.valid) begin
                o_res.item.record_kind = KIND_END;
            end
            o_res.valid              = 1'b1;
            o_res.item.last          = 1'b1;
            o_res.item.descriptor_ok = (w_walk_phase == PH_DONE);
        end
    end

    // State registers advance only when the item is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_key_store   <= '0;
            r_name_left   <= '0;
            r_trans_left  <= '0;
            r_svc_left    <= '0;
            r_svc_high    <= '0;
            r_trans_index <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_key_store   <= n_key_store;
            r_name_left   <= n_name_left;
            r_trans_left  <= n_trans_left;
            r_svc_left    <= n_svc_left;
            r_svc_high    <= n_svc_high;
            r_trans_index <= n_trans_index;
        end
    end

endmodule

/* rtl/ts_info_descriptor_parser.sv */
// Top level: input register, parser step and output register.
// An accepted byte waits in the input register; its record goes to the output register.
// Throughput: one byte per cycle; the input register drains whenever the output register
// is empty or its record is taken in the same cycle.
// Reset (synchronous, active low) empties both registers and returns the parser to idle
// with all counters cleared.
module ts_info_descriptor_parser
    import tidp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    logic      w_advance;
    logic      w_in_accept;
    logic      w_out_take;
    t_step_res w_res;

    // The held byte moves on when the output register has room for its record.
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    tidp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_item  (r_in_item),
        .o_res   (w_res)
    );

    // Input register occupancy.
    always_comb begin
        priority if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    // Output register occupancy.
    always_comb begin
        priority if (w_advance && w_res.valid) begin
            n_out_valid = 1'b1;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
        if (w_advance && w_res.valid) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A good-structure flag only ever rides on the closing record.
    a_ok_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.descriptor_ok |-> o_out_item.last)
        else $error("descriptor_ok set on a record without last");

    // An end-only record always closes the descriptor.
    a_end_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.record_kind == KIND_END) |-> o_out_item.last)
        else $error("end-only record without last");

    // Record kinds stay within the defined set.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.record_kind <= KIND_END))
        else $error("undefined record kind");

    // Stall toward the source only while a byte is held and the output is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

    // A held record that is not taken is not overwritten.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_item))
        else $error("stalled record changed");

endmodule

/* dv/tidp_checker.sv */
`timescale 1ns / 1ps
// Checker for the TS information descriptor parser: predicts records and compares them.
module tidp_checker
    import tidp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_records_due
);

    // Parser state as seen by the predictor.
    t_phase     phase_q;
    logic [7:0] key_q;
    logic [5:0] name_left;
    logic [1:0] trans_left;
    logic [1:0] trans_idx;
    logic [7:0] svc_left;
    logic [7:0] held_byte;

    t_out_item  records_due[$];
    int         fail_count = 0;
    int         due_count = 0;

    assign o_fail_count  = fail_count;
    assign o_records_due = due_count;

    // Phase that follows the name, or a finished transmission entry.
    function automatic t_phase entry_phase();
        return (trans_left != 2'd0) ? PH_TTYPE : PH_DONE;
    endfunction

    // Closes one transmission entry and moves to the next one.
    task automatic close_entry();
        trans_left = trans_left - 2'd1;
        trans_idx  = trans_idx + 2'd1;
        phase_q    = entry_phase();
    endtask

    // Walks one payload byte and tells whether it completes a record.
    task automatic parse_byte(input t_in_item it, output bit have, output t_out_item rec);
        logic [7:0] b;
        b    = it.byte_value;
        rec  = '0;
        have = 1'b0;
        if (it.start_flag) begin
            phase_q = PH_KEY;
        end
        // With no descriptor open the byte is dropped, end flag or not.
        if (phase_q == PH_IDLE) begin
            return;
        end
        unique case (phase_q)
            PH_KEY: begin
                key_q   = b;
                phase_q = PH_LEN;
            end
            PH_LEN: begin
                name_left           = b[7:2];
                trans_left          = b[1:0];
                trans_idx           = 2'd0;
                rec.record_kind     = KIND_HEADER;
                rec.key_id          = key_q;
                rec.name_length     = b[7:2];
                rec.type_count      = b[1:0];
                have                = 1'b1;
                phase_q             = (name_left != 6'd0) ? PH_NAME : entry_phase();
            end
            PH_NAME: begin
                rec.record_kind = KIND_NAME;
                rec.field_value = {8'd0, b};
                have            = 1'b1;
                name_left       = name_left - 6'd1;
                if (name_left == 6'd0) begin
                    phase_q = entry_phase();
                end
            end
            PH_TTYPE: begin
                held_byte = b;
                phase_q   = PH_TCOUNT;
            end
            PH_TCOUNT: begin
                rec.record_kind        = KIND_TRANS;
                rec.field_value        = {8'd0, held_byte};
                rec.service_count      = b;
                rec.transmission_index = trans_idx;
                have                   = 1'b1;
                svc_left               = b;
                if (b == 8'd0) begin
                    close_entry();
                end else begin
                    phase_q = PH_SVCHI;
                end
            end
            PH_SVCHI: begin
                held_byte = b;
                phase_q   = PH_SVCLO;
            end
            PH_SVCLO: begin
                rec.record_kind        = KIND_SVC;
                rec.field_value        = {held_byte, b};
                rec.transmission_index = trans_idx;
                have                   = 1'b1;
                svc_left               = svc_left - 8'd1;
                if (svc_left == 8'd0) begin
                    close_entry();
                end else begin
                    phase_q = PH_SVCHI;
                end
            end
            default: begin
                // Reserved tail after the structure: nothing to report.
            end
        endcase
        // The end byte always carries last; ok only if the structure was complete.
        if (it.end_flag) begin
            if (!have) begin
                rec.record_kind = KIND_END;
                have            = 1'b1;
            end
            rec.last          = 1'b1;
            rec.descriptor_ok = (phase_q == PH_DONE);
            phase_q           = PH_IDLE;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare taken records against the oldest prediction, then predict from taken bytes.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item rec;
        bit        have;
        if (!i_rst_n) begin
            phase_q    = PH_IDLE;
            key_q      = 8'd0;
            name_left  = 6'd0;
            trans_left = 2'd0;
            trans_idx  = 2'd0;
            svc_left   = 8'd0;
            held_byte  = 8'd0;
            records_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (records_due.size() == 0) begin
                    $error("record taken with none expected: kind %0d",
                           i_out_item.record_kind);
                    fail_count++;
                end else begin
                    want = records_due.pop_front();
                    check_field("record_kind", want.record_kind, i_out_item.record_kind);
                    check_field("key_id", want.key_id, i_out_item.key_id);
                    check_field("name_length", want.name_length, i_out_item.name_length);
                    check_field("type_count", want.type_count, i_out_item.type_count);
                    check_field("field_value", want.field_value, i_out_item.field_value);
                    check_field("service_count", want.service_count,
                                i_out_item.service_count);
                    check_field("transmission_index", want.transmission_index,
                                i_out_item.transmission_index);
                    check_field("last", want.last, i_out_item.last);
                    check_field("descriptor_ok", want.descriptor_ok,
                                i_out_item.descriptor_ok);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_in_item, have, rec);
                if (have) begin
                    records_due = {records_due, rec};
                end
            end
        end
        due_count = records_due.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, descriptor byte stimulus, stall pattern and verdict.
module tb
    import tidp_pkg::*;
();

    localparam int RANDOM_BYTES   = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        records_due;

    // When set, neither side idles.
    bit        quiet = 1'b0;
    int        idle_cycles = 0;

    ts_info_descriptor_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    tidp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_records_due(records_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Result side: stall in random bursts, changed only at falling edges.
    initial begin
        int   run;
        logic level;
        out_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                level = ($urandom_range(0, 2) == 0);
                run   = level ? pick_gap() : $urandom_range(1, 8);
                if (run == 0) begin
                    level = 1'b0;
                    run   = 1;
                end
            end
            out_stall <= quiet ? 1'b0 : level;
            run--;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one byte and returns at the falling edge after it is taken.
    task automatic send_item(input logic [7:0] b, input logic s, input logic e);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= {b, s, e};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Holds the sender back until every predicted record has been taken.
    task automatic drain_records();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (records_due != 0);
    endtask

    initial begin
        logic [7:0] body[$];
        int         sent;
        int         r;
        int         cut;
        int         nlen;
        int         cnt;
        int         sc;
        bit         restart;
        bit         drained;

        in_valid = 1'b0;
        in_item  = '0;
        i_rst_n  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Bytes outside any descriptor are dropped, end flag included.
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        // Start and end on one byte.
        send_item(8'hA5, 1'b1, 1'b1);
        // Full descriptor: two name chars, two entries, the last with no services.
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h0A, 1'b0, 1'b0);
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'h42, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // A new start abandons the open descriptor; then it ends too early.
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h07, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        // Empty structure followed by a reserved tail, closed by an end-only record.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h77, 1'b0, 1'b0);
        send_item(8'h88, 1'b0, 1'b1);
        // Longest name and full entry count, cut short by the end byte.
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b0, 1'b1);
        // End on the length byte while entries are still owed.
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h03, 1'b0, 1'b1);
        drain_records();

        // Random descriptors, mostly well formed, with noise, truncation and restarts.
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                quiet = !quiet;
            end
            if (r < 10) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0,
                              1'($urandom_range(0, 1)));
                end
            end else begin
                body.delete();
                body = {body, 8'($urandom_range(0, 255))};
                nlen = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(0, 6);
                cnt  = $urandom_range(0, 3);
                body = {body, {nlen[5:0], cnt[1:0]}};
                repeat (nlen) body = {body, 8'($urandom_range(0, 255))};
                repeat (cnt) begin
                    body = {body, 8'($urandom_range(0, 255))};
                    sc = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 255)
                                                      : $urandom_range(0, 3);
                    body = {body, sc[7:0]};
                    repeat (2 * sc) body = {body, 8'($urandom_range(0, 255))};
                end
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 3)) body = {body, 8'($urandom_range(0, 255))};
                end
                cut     = body.size();
                restart = 1'b0;
                if (r < 28) begin
                    cut = $urandom_range(1, body.size());
                end else if (r < 33) begin
                    cut     = $urandom_range(1, body.size());
                    restart = 1'b1;
                end
                for (int i = 0; i < cut; i++) begin
                    send_item(body[i], i == 0, (i == cut - 1) && !restart);
                end
                sent += cut;
            end
            if (!drained && sent >= RANDOM_BYTES / 2) begin
                drain_records();
                drained = 1'b1;
            end
        end

        // Wait for every predicted record to be taken, then settle.
        quiet = 1'b0;
        drain_records();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* ts_info_descriptor_parser.f */
rtl/tidp_pkg.sv
rtl/tidp_parser.sv
rtl/ts_info_descriptor_parser.sv
dv/tidp_checker.sv
dv/tb.sv
